// ===== sv/ccc_pkg.sv =====
package ccc_pkg;

  // Year counter width; the mod-400 reciprocal below is sized for 16 bits.
  localparam int YEAR_BITS = 16;
  localparam int Y400_BITS = 9;

  localparam logic [YEAR_BITS-1:0] RESET_YEAR = YEAR_BITS'(2000);
  // Year 2000 is a multiple of 400.
  localparam logic [Y400_BITS-1:0] RESET_Y400 = '0;

  // Year mod 400 by reciprocal: q = (y * RECIP_400) >> RECIP_SHIFT, exact for 16-bit y.
  localparam int RECIP_BITS  = 17;
  localparam int RECIP_SHIFT = 25;
  localparam logic [RECIP_BITS-1:0] RECIP_400 = RECIP_BITS'(83887);
  localparam int PROD_BITS = YEAR_BITS + RECIP_BITS;
  localparam int QUOT_BITS = PROD_BITS - RECIP_SHIFT;

  // Item kinds
  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_SET  = 1'b1;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  localparam logic [5:0] LAST_SEC  = 6'd59;
  localparam logic [5:0] LAST_MIN  = 6'd59;
  localparam logic [4:0] LAST_HOUR = 5'd23;
  localparam logic [4:0] NOON      = 5'd12;
  localparam logic [Y400_BITS-1:0] LAST_Y400 = Y400_BITS'(399);

  // Days in a month; month must be 1..12, anything else reads as January.
  function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
    logic [4:0] days;
    begin
      unique case (month)
        4'd2:                      days = leap ? 5'd29 : 5'd28;
        4'd4, 4'd6, 4'd9, 4'd11:   days = 5'd30;
        default:                   days = 5'd31;
      endcase
      return days;
    end
  endfunction

  // Leap test from the year's residue mod 400.
  function automatic logic leap_from_y400(input logic [Y400_BITS-1:0] y400);
    return (y400[1:0] == 2'b00) && (y400 != Y400_BITS'(100)) &&
           (y400 != Y400_BITS'(200)) && (y400 != Y400_BITS'(300));
  endfunction

endpackage

// ===== sv/calendar_clock_counter_unit.sv =====
// An accepted beat is held in the input stage, then applied in the update of the clock state.
// Throughput: one beat per cycle while out_ready holds; the output register refills in the cycle it is taken.
// The leap rule runs off a year-mod-400 counter kept with the year; a set beat gets its
// residue from one reciprocal multiply in the input stage.
// Reset (rst_n low, synchronous): 2000-01-01 00:00:00, both stages empty.
module calendar_clock_counter_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_kind,
  input  logic [3:0]                     in_set_month,
  input  logic [4:0]                     in_set_day,
  input  logic signed [16:0]             in_set_year,
  input  logic [4:0]                     in_set_hour,
  input  logic [5:0]                     in_set_minute,
  input  logic [5:0]                     in_set_second,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [3:0]                     out_month,
  output logic [4:0]                     out_day,
  output logic [ccc_pkg::YEAR_BITS-1:0]  out_year,
  output logic [4:0]                     out_hour,
  output logic [5:0]                     out_minute,
  output logic [5:0]                     out_second,
  output logic [3:0]                     out_hour_twelve,
  output logic                           out_is_pm
);
  import ccc_pkg::*;

  // Input stage
  logic                  a_vld_r;
  logic                  a_kind_r;
  logic [3:0]            a_month_r;
  logic [4:0]            a_day_r;
  logic [YEAR_BITS-1:0]  a_year_r;
  logic [Y400_BITS-1:0]  a_y400_r;
  logic [4:0]            a_hour_r;
  logic [5:0]            a_min_r;
  logic [5:0]            a_sec_r;

  // Clock state, which doubles as the result register
  logic                  out_vld_r;
  logic [3:0]            month_r,  month_nxt;
  logic [4:0]            day_r,    day_nxt;
  logic [YEAR_BITS-1:0]  year_r,   year_nxt;
  logic [Y400_BITS-1:0]  y400_r,   y400_nxt;
  logic [4:0]            hour_r,   hour_nxt;
  logic [5:0]            min_r,    min_nxt;
  logic [5:0]            sec_r,    sec_nxt;
  logic [3:0]            h12_r,    h12_nxt;
  logic                  pm_r,     pm_nxt;

  logic                  in_acc;
  logic                  b_load;

  // Set-year residue mod 400
  logic                  set_neg;
  logic [YEAR_BITS-1:0]  set_year_lo;
  logic [YEAR_BITS-1:0]  set_year;
  logic [PROD_BITS-1:0]  set_prod;
  logic [QUOT_BITS-1:0]  set_quot;
  logic [YEAR_BITS-1:0]  set_q400;
  logic [YEAR_BITS-1:0]  set_rem;

  // Tick path
  logic                  sec_c, min_c, hour_c, day_c, mon_c;
  logic [4:0]            cur_days;
  logic [Y400_BITS-1:0]  y400_inc;

  // Set path
  logic [3:0]            ld_month;
  logic [4:0]            ld_days;

  // Handshake
  assign b_load   = a_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !a_vld_r || b_load;
  assign in_acc   = in_valid && in_ready;

  // Reduce the set year mod 400 ahead of the input register
  assign set_neg     = in_set_year[16];
  assign set_year_lo = in_set_year[YEAR_BITS-1:0];
  assign set_year    = set_neg ? RESET_YEAR : set_year_lo;
  assign set_prod    = PROD_BITS'(set_year_lo) * PROD_BITS'(RECIP_400);
  assign set_quot    = set_prod[PROD_BITS-1:RECIP_SHIFT];
  assign set_q400    = YEAR_BITS'({set_quot, 8'b0}) + YEAR_BITS'({set_quot, 7'b0})
                     + YEAR_BITS'({set_quot, 4'b0});
  assign set_rem     = set_year_lo - set_q400;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (in_ready) begin
      a_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_kind_r  <= in_kind;
      a_month_r <= in_set_month;
      a_day_r   <= in_set_day;
      a_year_r  <= set_year;
      a_y400_r  <= set_neg ? RESET_Y400 : set_rem[Y400_BITS-1:0];
      a_hour_r  <= in_set_hour;
      a_min_r   <= in_set_minute;
      a_sec_r   <= in_set_second;
    end
  end

  // Carry chain for one tick
  assign cur_days = month_days(month_r, leap_from_y400(y400_r));
  assign sec_c    = sec_r >= LAST_SEC;
  assign min_c    = min_r >= LAST_MIN;
  assign hour_c   = hour_r >= LAST_HOUR;
  assign day_c    = day_r >= cur_days;
  assign mon_c    = month_r >= MONTH_DEC;
  assign y400_inc = (y400_r == LAST_Y400) ? '0 : y400_r + 1'b1;

  // Validated load values
  assign ld_month = (a_month_r >= MONTH_JAN && a_month_r <= MONTH_DEC) ? a_month_r : MONTH_JAN;
  assign ld_days  = month_days(ld_month, leap_from_y400(a_y400_r));

  // Next clock state
  always_comb begin
    month_nxt = month_r;
    day_nxt   = day_r;
    year_nxt  = year_r;
    y400_nxt  = y400_r;
    hour_nxt  = hour_r;
    min_nxt   = min_r;
    sec_nxt   = sec_r;
    if (a_kind_r == KIND_SET) begin
      month_nxt = ld_month;
      year_nxt  = a_year_r;
      y400_nxt  = a_y400_r;
      day_nxt   = (a_day_r != 5'd0 && a_day_r <= ld_days) ? a_day_r : 5'd1;
      hour_nxt  = (a_hour_r <= LAST_HOUR) ? a_hour_r : 5'd0;
      min_nxt   = (a_min_r <= LAST_MIN) ? a_min_r : 6'd0;
      sec_nxt   = (a_sec_r <= LAST_SEC) ? a_sec_r : 6'd0;
    end else begin
      sec_nxt = sec_c ? 6'd0 : sec_r + 6'd1;
      if (sec_c) begin
        min_nxt = min_c ? 6'd0 : min_r + 6'd1;
        if (min_c) begin
          hour_nxt = hour_c ? 5'd0 : hour_r + 5'd1;
          if (hour_c) begin
            day_nxt = day_c ? 5'd1 : day_r + 5'd1;
            if (day_c) begin
              month_nxt = mon_c ? MONTH_JAN : month_r + 4'd1;
              if (mon_c) begin
                // A wrap to year 0 restarts the residue at 0
                year_nxt = year_r + 1'b1;
                y400_nxt = (&year_r) ? '0 : y400_inc;
              end
            end
          end
        end
      end
    end
  end

  // 12-hour form
  always_comb begin
    pm_nxt = hour_nxt >= NOON;
    priority if (hour_nxt == 5'd0 || hour_nxt == NOON) begin
      h12_nxt = 4'd12;
    end else if (pm_nxt) begin
      h12_nxt = 4'(hour_nxt - NOON);
    end else begin
      h12_nxt = hour_nxt[3:0];
    end
  end

  // Update state and hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      month_r   <= MONTH_JAN;
      day_r     <= 5'd1;
      year_r    <= RESET_YEAR;
      y400_r    <= RESET_Y400;
      hour_r    <= 5'd0;
      min_r     <= 6'd0;
      sec_r     <= 6'd0;
      h12_r     <= 4'd12;
      pm_r      <= 1'b0;
    end else begin
      if (b_load) begin
        out_vld_r <= 1'b1;
        month_r   <= month_nxt;
        day_r     <= day_nxt;
        year_r    <= year_nxt;
        y400_r    <= y400_nxt;
        hour_r    <= hour_nxt;
        min_r     <= min_nxt;
        sec_r     <= sec_nxt;
        h12_r     <= h12_nxt;
        pm_r      <= pm_nxt;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_vld_r;
  assign out_month       = month_r;
  assign out_day         = day_r;
  assign out_year        = year_r;
  assign out_hour        = hour_r;
  assign out_minute      = min_r;
  assign out_second      = sec_r;
  assign out_hour_twelve = h12_r;
  assign out_is_pm       = pm_r;

  // Time fields stay in range
  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    sec_r <= LAST_SEC && min_r <= LAST_MIN && hour_r <= LAST_HOUR)
    else $error("time field out of range");

  // Date fields stay in range
  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    month_r >= MONTH_JAN && month_r <= MONTH_DEC && day_r != 5'd0 && day_r <= cur_days)
    else $error("date field out of range");

  // A tick below the minute boundary advances the second by one
  a_tick_step: assert property (@(posedge clk) disable iff (!rst_n)
    b_load && a_kind_r == KIND_TICK && !sec_c |=> sec_r == $past(sec_r) + 6'd1)
    else $error("tick did not advance second");

  // An empty input stage always takes a beat
  a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
    !a_vld_r |-> in_ready)
    else $error("input stage empty but not ready");

  // AM/PM flag agrees with the 24-hour value
  a_pm_flag: assert property (@(posedge clk) disable iff (!rst_n)
    pm_r == (hour_r >= NOON))
    else $error("pm flag mismatch");

endmodule

// ===== tb/calendar_time_checker.sv =====
module calendar_time_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic                           in_kind,
  input  logic [3:0]                     in_set_month,
  input  logic [4:0]                     in_set_day,
  input  logic signed [16:0]             in_set_year,
  input  logic [4:0]                     in_set_hour,
  input  logic [5:0]                     in_set_minute,
  input  logic [5:0]                     in_set_second,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [3:0]                     out_month,
  input  logic [4:0]                     out_day,
  input  logic [ccc_pkg::YEAR_BITS-1:0]  out_year,
  input  logic [4:0]                     out_hour,
  input  logic [5:0]                     out_minute,
  input  logic [5:0]                     out_second,
  input  logic [3:0]                     out_hour_twelve,
  input  logic                           out_is_pm,
  output int                             mismatch_count,
  output int                             outstanding_results,
  output int                             results_checked
);
  import ccc_pkg::*;

  typedef struct packed {
    logic [3:0]           month;
    logic [4:0]           day;
    logic [YEAR_BITS-1:0] year;
    logic [4:0]           hour;
    logic [5:0]           minute;
    logic [5:0]           second;
  } clock_time_t;

  clock_time_t clock_now;
  clock_time_t want;
  clock_time_t expected_times[$];
  logic [3:0]  want_h12;
  logic        want_pm;
  int          errors;
  int          checked;

  initial begin
    mismatch_count      = 0;
    outstanding_results = 0;
    results_checked     = 0;
    errors              = 0;
    checked             = 0;
  end

  function automatic logic leap_year(input logic [YEAR_BITS-1:0] year);
    int unsigned y;
    y = year;
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  function automatic logic [4:0] month_length(input logic [3:0] month,
                                              input logic [YEAR_BITS-1:0] year);
    case (month)
      MONTH_FEB:               month_length = leap_year(year) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: month_length = 5'd30;
      default:                 month_length = 5'd31;
    endcase
  endfunction

  // Work out the date and time that a beat leaves behind.
  function automatic clock_time_t calendar_after_beat(
    input clock_time_t        t,
    input logic               kind,
    input logic [3:0]         m,
    input logic [4:0]         d,
    input logic signed [16:0] y,
    input logic [4:0]         h,
    input logic [5:0]         mi,
    input logic [5:0]         s
  );
    clock_time_t n;
    n = t;
    if (kind == KIND_SET) begin
      // Load with cleanup of out-of-range fields.
      n.month  = (m >= MONTH_JAN && m <= MONTH_DEC) ? m : MONTH_JAN;
      n.year   = y[16] ? RESET_YEAR : y[YEAR_BITS-1:0];
      n.day    = (d >= 5'd1 && d <= month_length(n.month, n.year)) ? d : 5'd1;
      n.hour   = (h <= LAST_HOUR) ? h : 5'd0;
      n.minute = (mi <= LAST_MIN) ? mi : 6'd0;
      n.second = (s <= LAST_SEC) ? s : 6'd0;
    end else begin
      // Advance one second and ripple the carries up to the year.
      if (n.second >= LAST_SEC) begin
        n.second = 6'd0;
        if (n.minute >= LAST_MIN) begin
          n.minute = 6'd0;
          if (n.hour >= LAST_HOUR) begin
            n.hour = 5'd0;
            if (n.day >= month_length(n.month, n.year)) begin
              n.day = 5'd1;
              if (n.month >= MONTH_DEC) begin
                n.month = MONTH_JAN;
                n.year  = n.year + 1'b1;
              end else begin
                n.month = n.month + 1'b1;
              end
            end else begin
              n.day = n.day + 1'b1;
            end
          end else begin
            n.hour = n.hour + 1'b1;
          end
        end else begin
          n.minute = n.minute + 1'b1;
        end
      end else begin
        n.second = n.second + 1'b1;
      end
    end
    return n;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      clock_now.month  = MONTH_JAN;
      clock_now.day    = 5'd1;
      clock_now.year   = RESET_YEAR;
      clock_now.hour   = 5'd0;
      clock_now.minute = 6'd0;
      clock_now.second = 6'd0;
      expected_times.delete();
    end else begin
      // Predict on every accepted input beat.
      if (in_valid && in_ready) begin
        clock_now = calendar_after_beat(clock_now, in_kind, in_set_month, in_set_day,
                                        in_set_year, in_set_hour, in_set_minute,
                                        in_set_second);
        expected_times.push_back(clock_now);
      end
      // Compare every accepted result beat with the oldest prediction.
      if (out_valid && out_ready) begin
        checked++;
        if (expected_times.size() == 0) begin
          errors++;
          $display("%0t: result beat with nothing expected, actual %0d-%0d-%0d %0d:%0d:%0d",
                   $time, out_year, out_month, out_day, out_hour, out_minute, out_second);
        end else begin
          want     = expected_times.pop_front();
          want_h12 = (want.hour == 5'd0 || want.hour == NOON) ? 4'd12 : 4'(want.hour % 12);
          want_pm  = (want.hour >= NOON);
          if (out_month != want.month || out_day != want.day || out_year != want.year ||
              out_hour != want.hour || out_minute != want.minute ||
              out_second != want.second || out_hour_twelve != want_h12 ||
              out_is_pm != want_pm) begin
            errors++;
            $display({"%0t: mismatch, expected %0d-%0d-%0d %0d:%0d:%0d h12=%0d pm=%0b,",
                      " actual %0d-%0d-%0d %0d:%0d:%0d h12=%0d pm=%0b"},
                     $time, want.year, want.month, want.day, want.hour, want.minute,
                     want.second, want_h12, want_pm, out_year, out_month, out_day,
                     out_hour, out_minute, out_second, out_hour_twelve, out_is_pm);
          end
        end
      end
    end
    mismatch_count      <= errors;
    outstanding_results <= expected_times.size();
    results_checked     <= checked;
  end

endmodule

// ===== tb/calendar_clock_counter_unit_tb.sv =====
module calendar_clock_counter_unit_tb;
  import ccc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_BEATS = 550;

  typedef struct packed {
    logic               kind;
    logic [3:0]         month;
    logic [4:0]         day;
    logic signed [16:0] year;
    logic [4:0]         hour;
    logic [5:0]         minute;
    logic [5:0]         second;
  } calendar_beat_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_kind = KIND_TICK;
  logic [3:0]            in_set_month = '0;
  logic [4:0]            in_set_day = '0;
  logic signed [16:0]    in_set_year = '0;
  logic [4:0]            in_set_hour = '0;
  logic [5:0]            in_set_minute = '0;
  logic [5:0]            in_set_second = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [3:0]            out_month;
  logic [4:0]            out_day;
  logic [YEAR_BITS-1:0]  out_year;
  logic [4:0]            out_hour;
  logic [5:0]            out_minute;
  logic [5:0]            out_second;
  logic [3:0]            out_hour_twelve;
  logic                  out_is_pm;

  int mismatch_count;
  int outstanding_results;
  int results_checked;
  int cycle_count = 0;
  int send_idle_pct = 16;
  int recv_idle_pct = 60;
  int ticks_sent = 0;
  int loads_sent = 0;

  calendar_clock_counter_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_kind(in_kind),
    .in_set_month(in_set_month), .in_set_day(in_set_day), .in_set_year(in_set_year),
    .in_set_hour(in_set_hour), .in_set_minute(in_set_minute),
    .in_set_second(in_set_second),
    .out_valid(out_valid), .out_ready(out_ready), .out_month(out_month),
    .out_day(out_day), .out_year(out_year), .out_hour(out_hour),
    .out_minute(out_minute), .out_second(out_second),
    .out_hour_twelve(out_hour_twelve), .out_is_pm(out_is_pm)
  );

  calendar_time_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_kind(in_kind),
    .in_set_month(in_set_month), .in_set_day(in_set_day), .in_set_year(in_set_year),
    .in_set_hour(in_set_hour), .in_set_minute(in_set_minute),
    .in_set_second(in_set_second),
    .out_valid(out_valid), .out_ready(out_ready), .out_month(out_month),
    .out_day(out_day), .out_year(out_year), .out_hour(out_hour),
    .out_minute(out_minute), .out_second(out_second),
    .out_hour_twelve(out_hour_twelve), .out_is_pm(out_is_pm),
    .mismatch_count(mismatch_count), .outstanding_results(outstanding_results),
    .results_checked(results_checked)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Stall the result channel at the current rate.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  function automatic calendar_beat_t load_beat(input int m, input int d, input int y,
                                               input int h, input int mi, input int s);
    calendar_beat_t b;
    b.kind   = KIND_SET;
    b.month  = 4'(m);
    b.day    = 5'(d);
    b.year   = 17'(y);
    b.hour   = 5'(h);
    b.minute = 6'(mi);
    b.second = 6'(s);
    return b;
  endfunction

  // Tick with junk in the load fields, which the block must ignore.
  function automatic calendar_beat_t tick_beat();
    calendar_beat_t b;
    logic [63:0]    junk;
    junk   = {$urandom, $urandom};
    b      = junk[$bits(calendar_beat_t)-1:0];
    b.kind = KIND_TICK;
    return b;
  endfunction

  function automatic int calendar_year_pick();
    case ($urandom_range(0, 7))
      0:       return 2000;
      1:       return 1900;
      2:       return 2100;
      3:       return 2024;
      4:       return 2023;
      5:       return 65535;
      6:       return 0;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  // Present one beat, with an optional idle gap first, and hold it until taken.
  task automatic drive_beat(input calendar_beat_t b);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < send_idle_pct) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_kind       <= b.kind;
    in_set_month  <= b.month;
    in_set_day    <= b.day;
    in_set_year   <= b.year;
    in_set_hour   <= b.hour;
    in_set_minute <= b.minute;
    in_set_second <= b.second;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (b.kind == KIND_SET) loads_sent++;
    else ticks_sent++;
  endtask

  // Hold off the sender until every predicted result has come back.
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding_results != 0) @(posedge clk);
  endtask

  task automatic drive_ticks(input int count);
    repeat (count) drive_beat(tick_beat());
  endtask

  // Mostly loads parked just short of a rollover followed by tick bursts, plus noise.
  task automatic run_calendar_phase(input int count);
    int sent;
    int pick;
    int burst;
    int day_val;
    int hour_val;
    int minute_val;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        day_val    = ($urandom_range(0, 99) < 75) ? $urandom_range(28, 31)
                                                  : $urandom_range(1, 31);
        hour_val   = ($urandom_range(0, 99) < 80) ? 23 : $urandom_range(0, 23);
        minute_val = ($urandom_range(0, 99) < 80) ? 59 : $urandom_range(0, 59);
        drive_beat(load_beat($urandom_range(1, 12), day_val, calendar_year_pick(),
                             hour_val, minute_val, $urandom_range(50, 59)));
        burst = ($urandom_range(0, 99) < 5) ? $urandom_range(60, 130)
                                            : $urandom_range(1, 12);
        drive_ticks(burst);
        sent += burst + 1;
      end else if (pick < 85) begin
        drive_beat(load_beat($urandom_range(0, 15), $urandom_range(0, 31),
                             $urandom_range(0, 131071), $urandom_range(0, 31),
                             $urandom_range(0, 63), $urandom_range(0, 63)));
        sent++;
      end else begin
        burst = $urandom_range(1, 20);
        drive_ticks(burst);
        sent += burst;
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset state, leap rules, wraps, cleanup of bad fields, 12-hour form.
    drive_beat(tick_beat());
    drive_beat(load_beat(2, 28, 2000, 23, 59, 59));
    drive_beat(tick_beat());
    drive_beat(load_beat(2, 28, 1900, 23, 59, 59));
    drive_beat(tick_beat());
    drive_beat(load_beat(2, 29, 2024, 11, 30, 0));
    drive_beat(load_beat(2, 29, 2023, 12, 0, 0));
    drive_beat(load_beat(12, 31, 2023, 23, 59, 59));
    drive_beat(tick_beat());
    drive_beat(load_beat(4, 30, 2023, 23, 59, 59));
    drive_beat(tick_beat());
    drive_beat(load_beat(12, 31, 65535, 23, 59, 59));
    drive_beat(tick_beat());
    drive_beat(load_beat(2, 29, 0, 13, 0, 0));
    drive_beat(load_beat(0, 0, 0, 0, 0, 0));
    drive_beat(load_beat(13, 31, -1, 24, 60, 60));
    drive_beat(load_beat(15, 31, 32'h10000, 31, 63, 63));
    drive_beat(load_beat(4, 31, 65535, 12, 59, 59));
    drive_beat(load_beat(11, 15, 1999, 22, 45, 17));
    drive_beat(load_beat(6, 30, 2100, 23, 58, 59));
    drive_ticks(3);

    // Three idle mixes; pause for a full drain between them.
    hold_until_drained();
    run_calendar_phase(PHASE_BEATS);
    hold_until_drained();
    send_idle_pct = 60;
    recv_idle_pct = 16;
    run_calendar_phase(PHASE_BEATS);
    hold_until_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_calendar_phase(PHASE_BEATS);
    hold_until_drained();
    repeat (8) @(posedge clk);

    $display("covered %0d ticks and %0d loads, %0d results checked", ticks_sent, loads_sent,
             results_checked);
    $display("idle mixes: sender-light/receiver-heavy, reversed, then back-to-back");
    if (mismatch_count == 0 && outstanding_results == 0) begin
      $display("calendar_clock_counter_unit regression: pass");
    end else begin
      $display("calendar_clock_counter_unit regression: fail");
    end
    $finish;
  end

  // End the run if handshakes stop making progress.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles", cycle_count);
    $display("calendar_clock_counter_unit regression: fail");
    $finish;
  end

endmodule
